FILE: src/hwj_pkg.sv
// Shared constants, types and codes for the homography warp and Jacobian core.
package hwj_pkg;

   // Field sizes
   localparam int COORD_BITS = 12;
   localparam int FRAC_BITS  = 16;
   localparam int VAL_W      = 32;
   localparam int HEIGHT_W   = 13;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Internal datapath widths
   localparam int PROD_W = VAL_W + COORD_BITS + 1;
   localparam int SUM_W  = PROD_W;
   localparam int MAG_W  = SUM_W - 1;
   localparam int HALF_W = (MAG_W + 1) / 2;
   localparam int UPPER_W = MAG_W - HALF_W;
   localparam int LIM_W  = SUM_W + HEIGHT_W + 1;
   localparam int DEN_W  = 2 * MAG_W;
   localparam int NUM_W  = 2 * MAG_W + 2 * FRAC_BITS;
   localparam int QUOT_W = 32;
   localparam int DIV_LAT = QUOT_W + 2;
   localparam int LANES  = 11;

   // Stream payload widths
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W = ((LANES * VAL_W + STATUS_W + 7) / 8) * 8;

   // Saturation limits of a Q16.16 result
   localparam logic [VAL_W-1:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [VAL_W-1:0] SAT_NEG = 32'h8000_0000;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_A = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_B = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_C = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAIR_D = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_LAST   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT = 3'd5;

   // Divider lane assignment, also the order of values in rsp_tdata
   localparam int LN_WARP_COL  = 0;
   localparam int LN_WARP_ROW  = 1;
   localparam int LN_COL_DEN   = 2;
   localparam int LN_ROW_DEN   = 3;
   localparam int LN_INV_DEN   = 4;
   localparam int LN_FIRST_COL = 5;
   localparam int LN_FIRST_ROW = 6;
   localparam int LN_FIRST_ONE = 7;
   localparam int LN_SEC_COL   = 8;
   localparam int LN_SEC_ROW   = 9;
   localparam int LN_SEC_ONE   = 10;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_ROW_RANGE = 2'd1,
      ST_DEN_ZERO  = 2'd2
   } status_type;

   // Homography coefficients h0..h8, signed fixed point
   typedef logic [8:0][VAL_W-1:0] coef_type;

   // Front end to divider lanes
   typedef struct packed {
      logic                              valid;
      logic                              dzero;
      logic                              beyond;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][NUM_W-1:0]       num;
      logic [LANES-1:0][DEN_W-1:0]       den;
   } front_type;

endpackage

FILE: src/homography_warp_with_jacobian_core.sv
// Homography warp core with Jacobian: config registers, pipeline, divider lanes, output skid.
//
// Takes one pixel coordinate per cycle while req_tready is high and returns the warped
// point and the nine Jacobian entries in Q16.16 with a status code. A result passes
// five front-end stages (products, sums, magnitudes, den^2 partial products, dividends),
// 34 stages in each of the eleven divider lanes (overflow test, 32 restoring steps,
// saturation) and the output register. Throughput is one item per clock while req_tready
// is high; the lanes retire one quotient bit per stage. An output skid register lets the
// pipe advance in the cycle a result is refused; req_tready then drops until the skid
// register drains into the output register, so back pressure stalls the whole pipe.
// The csr port is always ready; write registers only while the core is empty.
module homography_warp_with_jacobian_core (
   input  logic                            clock,
   input  logic                            reset,
   // req_tdata: pixel_col, pixel_row
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hwj_pkg::REQ_W-1:0]       req_tdata,
   // rsp_tdata: warped_col, warped_row, col_over_den, row_over_den, inv_den,
   // first_col_term, first_row_term, first_unit_term, second_col_term,
   // second_row_term, second_unit_term, status
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hwj_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hwj_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hwj_pkg::CSR_DATA_W-1:0]  csr_data
);
   import hwj_pkg::*;

   // Configuration registers
   logic [CSR_DATA_W-1:0] pair_a_ff, pair_b_ff, pair_c_ff, pair_d_ff;
   logic [VAL_W-1:0]      last_ff;
   logic [HEIGHT_W-1:0]   height_ff;
   coef_type              coef;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_a_ff <= CSR_DATA_W'(1) << (VAL_W + FRAC_BITS);
         pair_b_ff <= '0;
         pair_c_ff <= CSR_DATA_W'(1) << (VAL_W + FRAC_BITS);
         pair_d_ff <= '0;
         last_ff   <= VAL_W'(1) << FRAC_BITS;
         height_ff <= HEIGHT_W'(4096);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PAIR_A: pair_a_ff <= csr_data;
            REG_PAIR_B: pair_b_ff <= csr_data;
            REG_PAIR_C: pair_c_ff <= csr_data;
            REG_PAIR_D: pair_d_ff <= csr_data;
            REG_LAST:   last_ff   <= csr_data[VAL_W-1:0];
            REG_HEIGHT: height_ff <= csr_data[HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   assign coef[0] = pair_a_ff[2*VAL_W-1:VAL_W];
   assign coef[1] = pair_a_ff[VAL_W-1:0];
   assign coef[2] = pair_b_ff[2*VAL_W-1:VAL_W];
   assign coef[3] = pair_b_ff[VAL_W-1:0];
   assign coef[4] = pair_c_ff[2*VAL_W-1:VAL_W];
   assign coef[5] = pair_c_ff[VAL_W-1:0];
   assign coef[6] = pair_d_ff[2*VAL_W-1:VAL_W];
   assign coef[7] = pair_d_ff[VAL_W-1:0];
   assign coef[8] = last_ff;

   // Pipeline advance: held only while the skid register is occupied
   logic      skid_v_ff;
   logic      en;
   front_type fo;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   hwj_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_col   (req_tdata[COORD_BITS-1:0]),
      .in_row   (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .coef     (coef),
      .height   (height_ff),
      .fo       (fo)
   );

   // Divider lanes
   logic [LANES-1:0][VAL_W-1:0] quot;

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      hwj_div_lane u_lane (
         .clock  (clock),
         .en     (en),
         .in_num (fo.num[i]),
         .in_den (fo.den[i]),
         .in_neg (fo.neg[i]),
         .res    (quot[i])
      );
   end

   // Valid and flags travel beside the lanes
   logic [DIV_LAT-1:0] sv_ff, sz_ff, sb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= '0;
      end else if (en) begin
         sv_ff <= {sv_ff[DIV_LAT-2:0], fo.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sz_ff <= {sz_ff[DIV_LAT-2:0], fo.dzero};
         sb_ff <= {sb_ff[DIV_LAT-2:0], fo.beyond};
      end
   end

   // Result assembly
   logic             tail_valid;
   logic [RSP_W-1:0] tail_data;
   status_type       tail_status;

   always_comb begin
      tail_valid = sv_ff[DIV_LAT-1] && en;
      if (sz_ff[DIV_LAT-1]) begin
         tail_status = ST_DEN_ZERO;
      end else if (sb_ff[DIV_LAT-1]) begin
         tail_status = ST_ROW_RANGE;
      end else begin
         tail_status = ST_OK;
      end
      tail_data = '0;
      for (int i = 0; i < LANES; i++) begin
         tail_data[i*VAL_W +: VAL_W] = sz_ff[DIV_LAT-1] ? '0 : quot[i];
      end
      tail_data[LANES*VAL_W +: STATUS_W] = tail_status;
   end

   // Output register and skid register
   logic             out_v_ff, out_v_in, skid_v_in;
   logic [RSP_W-1:0] out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic             out_take;

   assign out_take = out_v_ff && rsp_tready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (skid_v_ff) begin
         if (out_take) begin
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end
      end else if (tail_valid) begin
         if (!out_v_ff || out_take) begin
            out_d_in = tail_data;
            out_v_in = 1'b1;
         end else begin
            skid_d_in = tail_data;
            skid_v_in = 1'b1;
         end
      end else if (out_take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff;

endmodule

FILE: src/hwj_front.sv
// Front end: products, projective sums, magnitudes, squared denominator and dividends.
module hwj_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [hwj_pkg::COORD_BITS-1:0] in_col,
   input  logic [hwj_pkg::COORD_BITS-1:0] in_row,
   input  hwj_pkg::coef_type             coef,
   input  logic [hwj_pkg::HEIGHT_W-1:0]  height,
   output hwj_pkg::front_type            fo
);
   import hwj_pkg::*;

   // Stage 1: coefficient times coordinate
   logic                         v1_ff;
   logic [COORD_BITS-1:0]        x1_ff, y1_ff;
   logic signed [PROD_W-1:0]     px_ff [0:2];
   logic signed [PROD_W-1:0]     py_ff [0:2];
   logic signed [PROD_W-1:0]     px_in [0:2];
   logic signed [PROD_W-1:0]     py_in [0:2];
   logic signed [COORD_BITS:0]   xs, ys;

   assign xs = $signed({1'b0, in_col});
   assign ys = $signed({1'b0, in_row});

   always_comb begin
      px_in[0] = $signed(coef[0]) * xs;
      px_in[1] = $signed(coef[3]) * xs;
      px_in[2] = $signed(coef[6]) * xs;
      py_in[0] = $signed(coef[1]) * ys;
      py_in[1] = $signed(coef[4]) * ys;
      py_in[2] = $signed(coef[7]) * ys;
   end

   // Stage 2: n, n2 and den
   logic                         v2_ff;
   logic [COORD_BITS-1:0]        x2_ff, y2_ff;
   logic signed [SUM_W-1:0]      n_ff, n2_ff, d_ff;
   logic signed [SUM_W-1:0]      n_in, n2_in, d_in;

   always_comb begin
      n_in  = px_ff[0] + py_ff[0] + SUM_W'($signed(coef[2]));
      n2_in = px_ff[1] + py_ff[1] + SUM_W'($signed(coef[5]));
      d_in  = px_ff[2] + py_ff[2] + SUM_W'($signed(coef[8]));
   end

   // Stage 3: magnitudes, signs and the row limit height*den
   logic                         v3_ff, dz3_ff, dneg3_ff, nneg3_ff, n2neg3_ff;
   logic [COORD_BITS-1:0]        x3_ff, y3_ff;
   logic [MAG_W-1:0]             dm3_ff, nm3_ff, n2m3_ff;
   logic signed [SUM_W-1:0]      n2s3_ff;
   logic signed [LIM_W-1:0]      lim3_ff;
   logic [MAG_W-1:0]             dm_in, nm_in, n2m_in;
   logic signed [LIM_W-1:0]      lim_in;

   always_comb begin
      dm_in  = d_ff[SUM_W-1]  ? MAG_W'(-d_ff)  : MAG_W'(d_ff);
      nm_in  = n_ff[SUM_W-1]  ? MAG_W'(-n_ff)  : MAG_W'(n_ff);
      n2m_in = n2_ff[SUM_W-1] ? MAG_W'(-n2_ff) : MAG_W'(n2_ff);
      lim_in = $signed({1'b0, height}) * d_ff;
   end

   // Stage 4: partial products of den^2, n*x style products, row test
   logic                          v4_ff, dz4_ff, dneg4_ff, nneg4_ff, n2neg4_ff, beyond4_ff;
   logic [COORD_BITS-1:0]         x4_ff, y4_ff;
   logic [MAG_W-1:0]              dm4_ff, nm4_ff, n2m4_ff;
   logic [2*HALF_W-1:0]           pp_ll_ff;
   logic [MAG_W-1:0]              pp_lh_ff, pp_hl_ff;
   logic [2*UPPER_W-1:0]          pp_hh_ff;
   logic [MAG_W+COORD_BITS-1:0]   nx_ff, ny_ff, mx_ff, my_ff;
   logic                          beyond_in;
   logic signed [LIM_W-1:0]       n2_wide;

   always_comb begin
      n2_wide   = LIM_W'(n2s3_ff);
      beyond_in = dneg3_ff ? (n2_wide <= lim3_ff) : (n2_wide >= lim3_ff);
   end

   // Stage 5: den^2 and the eleven dividend/divisor pairs
   front_type fo_ff, fo_in;
   logic [DEN_W-1:0] d2;
   logic [DEN_W-1:0] dm_ext;

   always_comb begin
      d2 = (DEN_W'(pp_hh_ff) << (2 * HALF_W))
         + ((DEN_W'(pp_lh_ff) + DEN_W'(pp_hl_ff)) << HALF_W)
         + DEN_W'(pp_ll_ff);
      dm_ext = DEN_W'(dm4_ff);

      fo_in.valid  = v4_ff;
      fo_in.dzero  = dz4_ff;
      fo_in.beyond = beyond4_ff;

      fo_in.num[LN_WARP_COL]  = NUM_W'(nm4_ff) << FRAC_BITS;
      fo_in.num[LN_WARP_ROW]  = NUM_W'(n2m4_ff) << FRAC_BITS;
      fo_in.num[LN_COL_DEN]   = NUM_W'(x4_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_ROW_DEN]   = NUM_W'(y4_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_INV_DEN]   = NUM_W'(1) << (2 * FRAC_BITS);
      fo_in.num[LN_FIRST_COL] = NUM_W'(nx_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_FIRST_ROW] = NUM_W'(ny_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_FIRST_ONE] = NUM_W'(nm4_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_SEC_COL]   = NUM_W'(mx_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_SEC_ROW]   = NUM_W'(my_ff) << (2 * FRAC_BITS);
      fo_in.num[LN_SEC_ONE]   = NUM_W'(n2m4_ff) << (2 * FRAC_BITS);

      fo_in.den[LN_WARP_COL]  = dm_ext;
      fo_in.den[LN_WARP_ROW]  = dm_ext;
      fo_in.den[LN_COL_DEN]   = dm_ext;
      fo_in.den[LN_ROW_DEN]   = dm_ext;
      fo_in.den[LN_INV_DEN]   = dm_ext;
      fo_in.den[LN_FIRST_COL] = d2;
      fo_in.den[LN_FIRST_ROW] = d2;
      fo_in.den[LN_FIRST_ONE] = d2;
      fo_in.den[LN_SEC_COL]   = d2;
      fo_in.den[LN_SEC_ROW]   = d2;
      fo_in.den[LN_SEC_ONE]   = d2;

      fo_in.neg[LN_WARP_COL]  = nneg4_ff ^ dneg4_ff;
      fo_in.neg[LN_WARP_ROW]  = n2neg4_ff ^ dneg4_ff;
      fo_in.neg[LN_COL_DEN]   = dneg4_ff;
      fo_in.neg[LN_ROW_DEN]   = dneg4_ff;
      fo_in.neg[LN_INV_DEN]   = dneg4_ff;
      fo_in.neg[LN_FIRST_COL] = !nneg4_ff;
      fo_in.neg[LN_FIRST_ROW] = !nneg4_ff;
      fo_in.neg[LN_FIRST_ONE] = !nneg4_ff;
      fo_in.neg[LN_SEC_COL]   = !n2neg4_ff;
      fo_in.neg[LN_SEC_ROW]   = !n2neg4_ff;
      fo_in.neg[LN_SEC_ONE]   = !n2neg4_ff;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= in_col;
         y1_ff <= in_row;
         px_ff <= px_in;
         py_ff <= py_in;

         x2_ff <= x1_ff;
         y2_ff <= y1_ff;
         n_ff  <= n_in;
         n2_ff <= n2_in;
         d_ff  <= d_in;

         x3_ff     <= x2_ff;
         y3_ff     <= y2_ff;
         dz3_ff    <= (d_ff == '0);
         dneg3_ff  <= d_ff[SUM_W-1];
         nneg3_ff  <= n_ff[SUM_W-1];
         n2neg3_ff <= n2_ff[SUM_W-1];
         dm3_ff    <= dm_in;
         nm3_ff    <= nm_in;
         n2m3_ff   <= n2m_in;
         n2s3_ff   <= n2_ff;
         lim3_ff   <= lim_in;

         x4_ff      <= x3_ff;
         y4_ff      <= y3_ff;
         dz4_ff     <= dz3_ff;
         dneg4_ff   <= dneg3_ff;
         nneg4_ff   <= nneg3_ff;
         n2neg4_ff  <= n2neg3_ff;
         beyond4_ff <= beyond_in;
         dm4_ff     <= dm3_ff;
         nm4_ff     <= nm3_ff;
         n2m4_ff    <= n2m3_ff;
         pp_ll_ff   <= dm3_ff[HALF_W-1:0] * dm3_ff[HALF_W-1:0];
         pp_lh_ff   <= dm3_ff[HALF_W-1:0] * dm3_ff[MAG_W-1:HALF_W];
         pp_hl_ff   <= dm3_ff[MAG_W-1:HALF_W] * dm3_ff[HALF_W-1:0];
         pp_hh_ff   <= dm3_ff[MAG_W-1:HALF_W] * dm3_ff[MAG_W-1:HALF_W];
         nx_ff      <= nm3_ff * x3_ff;
         ny_ff      <= nm3_ff * y3_ff;
         mx_ff      <= n2m3_ff * x3_ff;
         my_ff      <= n2m3_ff * y3_ff;
      end
   end

   // Stage 5 register; valid bit reset, payload free running under enable
   always_ff @(posedge clock) begin
      if (reset) begin
         fo_ff.valid <= 1'b0;
      end else if (en) begin
         fo_ff.valid <= fo_in.valid;
      end
      if (en) begin
         fo_ff.dzero  <= fo_in.dzero;
         fo_ff.beyond <= fo_in.beyond;
         fo_ff.neg    <= fo_in.neg;
         fo_ff.num    <= fo_in.num;
         fo_ff.den    <= fo_in.den;
      end
   end

   assign fo = fo_ff;

endmodule

FILE: src/hwj_div_lane.sv
// One divider lane: pipelined restoring division, one quotient bit per stage, then saturation.
module hwj_div_lane (
   input  logic                        clock,
   input  logic                        en,
   input  logic [hwj_pkg::NUM_W-1:0]   in_num,
   input  logic [hwj_pkg::DEN_W-1:0]   in_den,
   input  logic                        in_neg,
   output logic [hwj_pkg::VAL_W-1:0]   res
);
   import hwj_pkg::*;

   localparam int HI_W  = NUM_W - QUOT_W;
   localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

   logic [DEN_W-1:0]  rem_ff [0:QUOT_W];
   logic [DEN_W-1:0]  den_ff [0:QUOT_W];
   logic [QUOT_W-1:0] low_ff [0:QUOT_W];
   logic [QUOT_W-1:0] q_ff   [0:QUOT_W];
   logic              neg_ff [0:QUOT_W];
   logic              ovf_ff [0:QUOT_W];
   logic [VAL_W-1:0]  res_ff;

   logic [CMP_W-1:0]  hi_ext, den_ext;

   // Entry: quotient overflow test, upper dividend bits seed the remainder
   assign hi_ext  = CMP_W'(in_num[NUM_W-1:QUOT_W]);
   assign den_ext = CMP_W'(in_den);

   always_ff @(posedge clock) begin
      if (en) begin
         ovf_ff[0] <= (hi_ext >= den_ext);
         rem_ff[0] <= hi_ext[DEN_W-1:0];
         den_ff[0] <= in_den;
         low_ff[0] <= in_num[QUOT_W-1:0];
         q_ff[0]   <= '0;
         neg_ff[0] <= in_neg;
      end
   end

   // One trial subtraction per stage
   for (genvar s = 0; s < QUOT_W; s++) begin : g_step
      logic [DEN_W:0]   trial_in;
      logic             ge_in;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         trial_in = {rem_ff[s], low_ff[s][QUOT_W-1]};
         ge_in    = (trial_in >= {1'b0, den_ff[s]});
         rem_in   = ge_in ? DEN_W'(trial_in - {1'b0, den_ff[s]}) : trial_in[DEN_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s+1] <= rem_in;
            den_ff[s+1] <= den_ff[s];
            low_ff[s+1] <= {low_ff[s][QUOT_W-2:0], 1'b0};
            q_ff[s+1]   <= {q_ff[s][QUOT_W-2:0], ge_in};
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // Saturate magnitude and apply sign
   logic [VAL_W-1:0] limit, magn, res_in;

   always_comb begin
      limit  = neg_ff[QUOT_W] ? SAT_NEG : SAT_POS;
      magn   = (ovf_ff[QUOT_W] || (q_ff[QUOT_W] > limit)) ? limit : q_ff[QUOT_W];
      res_in = neg_ff[QUOT_W] ? VAL_W'(-magn) : magn;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

FILE: src/hwj_checker.sv
// Port-level checks for the homography warp core, attached by bind.
module hwj_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hwj_pkg::RSP_W-1:0]       rsp_tdata
);
   import hwj_pkg::*;

   localparam int ST_LSB = LANES * VAL_W;

   // A held result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   // Status code is never the unused value
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[ST_LSB +: STATUS_W] != 2'd3)
      else $error("undefined status code");

   // A zero denominator clears every value field
   a_den_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[ST_LSB +: STATUS_W] == ST_DEN_ZERO
         |-> rsp_tdata[ST_LSB-1:0] == '0)
      else $error("values not cleared on zero denominator");

   // Input stalls only after the result side refused an item
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> $past(rsp_tvalid && !rsp_tready))
      else $error("input stalled without back pressure");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result present after reset");

endmodule

bind homography_warp_with_jacobian_core hwj_checker u_hwj_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
